/* hdl/lesf_pkg.sv */
// Shared types and constants for the largest empty square finder.
package lesf_pkg;

    // Field widths fixed by the stream format
    localparam int CELL_W     = 8;
    localparam int POS_OUT_W  = 10;
    localparam int SIDE_OUT_W = 11;
    localparam int M_TDATA_W  = 32;

    // Map characters
    localparam logic [CELL_W-1:0] FREE_CHAR    = 8'h2E;   // '.'
    localparam logic [CELL_W-1:0] ROW_END_CHAR = 8'h0A;   // newline

    // Operation carried from the scan stage to the update stage
    localparam logic [1:0] OP_NOP     = 2'd0;
    localparam logic [1:0] OP_ROW_END = 2'd1;
    localparam logic [1:0] OP_CELL    = 2'd2;

    typedef struct packed {
        logic [1:0] op;
        logic       is_free;      // cell byte is '.'
        logic       above_valid;  // not row 0 and line store entry written since reset
        logic       last;         // map end beat
    } ctl_t;

endpackage

/* hdl/lesf_line_store.sv */
// One-row line store: synchronous RAM, one read and one write port.
module lesf_line_store #(
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = 10,
    parameter int DATA_W = 11
) (
    input  logic              clk,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* hdl/lesf_scan.sv */
// Scan stage: row/column tracking, overflow handling, line store fill mark.
module lesf_scan #(
    parameter int  MAX_COLS = 1024,
    parameter int  MAX_ROWS = 1024,
    localparam int COL_W    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1,
    localparam int ROW_W    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          accept,
    input  logic [lesf_pkg::CELL_W-1:0]   cell_byte,
    input  logic                          map_end,
    output lesf_pkg::ctl_t                ctl,
    output logic [COL_W-1:0]              col,
    output logic [ROW_W-1:0]              row
);
    import lesf_pkg::*;

    localparam int HWM_W = $clog2(MAX_COLS + 1);

    logic [COL_W-1:0] col_count_reg, col_count_next;
    logic [ROW_W-1:0] row_count_reg, row_count_next;
    logic             col_full_reg, col_full_next;
    logic             row_full_reg, row_full_next;
    // entries [0, hwm) have been written since reset
    logic [HWM_W-1:0] hwm_reg, hwm_next;

    always_comb
    begin
        col_count_next  = col_count_reg;
        row_count_next  = row_count_reg;
        col_full_next   = col_full_reg;
        row_full_next   = row_full_reg;
        hwm_next        = hwm_reg;
        ctl.op          = OP_NOP;
        ctl.is_free     = (cell_byte == FREE_CHAR);
        ctl.above_valid = (row_count_reg != '0) && (HWM_W'(col_count_reg) < hwm_reg);
        ctl.last        = map_end;

        if (!row_full_reg)
        begin
            if (cell_byte == ROW_END_CHAR)
            begin
                ctl.op         = OP_ROW_END;
                col_count_next = '0;
                col_full_next  = 1'b0;
                if (row_count_reg == ROW_W'(MAX_ROWS - 1))
                begin
                    row_full_next = 1'b1;
                end
                else
                begin
                    row_count_next = row_count_reg + 1'b1;
                end
            end
            else if (!col_full_reg)
            begin
                ctl.op = OP_CELL;
                if (HWM_W'(col_count_reg) == hwm_reg)
                begin
                    hwm_next = hwm_reg + 1'b1;
                end
                if (col_count_reg == COL_W'(MAX_COLS - 1))
                begin
                    col_full_next = 1'b1;
                end
                else
                begin
                    col_count_next = col_count_reg + 1'b1;
                end
            end
        end

        // new map starts after the end beat; fill mark survives
        if (map_end)
        begin
            col_count_next = '0;
            row_count_next = '0;
            col_full_next  = 1'b0;
            row_full_next  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_count_reg <= '0;
            row_count_reg <= '0;
            col_full_reg  <= 1'b0;
            row_full_reg  <= 1'b0;
            hwm_reg       <= '0;
        end
        else if (accept)
        begin
            col_count_reg <= col_count_next;
            row_count_reg <= row_count_next;
            col_full_reg  <= col_full_next;
            row_full_reg  <= row_full_next;
            hwm_reg       <= hwm_next;
        end
    end

    assign col = col_count_reg;
    assign row = row_count_reg;

`ifndef SYNTHESIS
    a_col_within_fill: assert property (@(posedge clk) disable iff (!rst_n)
        HWM_W'(col_count_reg) <= hwm_reg)
        else $error("column count ahead of line store fill mark");
`endif

endmodule

/* hdl/lesf_update.sv */
// Update stage: min-of-three side, best square tracking, result register.
module lesf_update #(
    parameter int  MAX_COLS = 1024,
    parameter int  MAX_ROWS = 1024,
    localparam int COL_W    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1,
    localparam int ROW_W    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
    localparam int MIN_DIM  = (MAX_COLS < MAX_ROWS) ? MAX_COLS : MAX_ROWS,
    localparam int SIDE_W   = $clog2(MIN_DIM + 1)
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              accept,
    input  lesf_pkg::ctl_t                    ctl_in,
    input  logic [COL_W-1:0]                  col_in,
    input  logic [ROW_W-1:0]                  row_in,
    input  logic [SIDE_W-1:0]                 rd_data,
    output logic                              stall,
    output logic                              wr_en,
    output logic [COL_W-1:0]                  wr_addr,
    output logic [SIDE_W-1:0]                 wr_data,
    input  logic                              m_tready,
    output logic                              m_tvalid,
    output logic [lesf_pkg::POS_OUT_W-1:0]    best_row,
    output logic [lesf_pkg::POS_OUT_W-1:0]    best_col,
    output logic [lesf_pkg::SIDE_OUT_W-1:0]   best_side
);
    import lesf_pkg::*;

    logic             s1_valid_reg;
    ctl_t             s1_ctl_reg;
    logic [COL_W-1:0] s1_col_reg;
    logic [ROW_W-1:0] s1_row_reg;

    logic [SIDE_W-1:0] left_reg, left_next;
    logic [SIDE_W-1:0] diag_reg, diag_next;
    logic [SIDE_W-1:0] best_size_reg, best_size_next;
    logic [ROW_W-1:0]  best_brow_reg, best_brow_next;
    logic [COL_W-1:0]  best_bcol_reg, best_bcol_next;

    logic              out_valid_reg;
    logic [POS_OUT_W-1:0]  out_row_reg;
    logic [POS_OUT_W-1:0]  out_col_reg;
    logic [SIDE_OUT_W-1:0] out_side_reg;

    logic              advance;
    logic [SIDE_W-1:0] up, m01, min3, side;
    logic [ROW_W-1:0]  top_row;
    logic [COL_W-1:0]  top_col;

    // hold the end beat while the result register is still occupied
    assign stall   = s1_valid_reg && s1_ctl_reg.last && out_valid_reg && !m_tready;
    assign advance = s1_valid_reg && !stall;

    assign up   = s1_ctl_reg.above_valid ? rd_data : '0;
    assign m01  = (up < left_reg) ? up : left_reg;
    assign min3 = (m01 < diag_reg) ? m01 : diag_reg;
    assign side = s1_ctl_reg.is_free ? (min3 + 1'b1) : '0;

    assign wr_en   = advance && (s1_ctl_reg.op == OP_CELL);
    assign wr_addr = s1_col_reg;
    assign wr_data = side;

    always_comb
    begin
        left_next      = left_reg;
        diag_next      = diag_reg;
        best_size_next = best_size_reg;
        best_brow_next = best_brow_reg;
        best_bcol_next = best_bcol_reg;
        case (s1_ctl_reg.op)
            OP_CELL:
            begin
                left_next = side;
                diag_next = up;
                if (side > best_size_reg)
                begin
                    best_size_next = side;
                    best_brow_next = s1_row_reg;
                    best_bcol_next = s1_col_reg;
                end
            end
            OP_ROW_END:
            begin
                left_next = '0;
                diag_next = '0;
            end
            default:
            begin
            end
        endcase
    end

    // top-left corner = bottom-right - (side - 1)
    always_comb
    begin
        top_row = '0;
        top_col = '0;
        if (best_size_next != '0)
        begin
            top_row = best_brow_next - ROW_W'(best_size_next - 1'b1);
            top_col = best_bcol_next - COL_W'(best_size_next - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            left_reg      <= '0;
            diag_reg      <= '0;
            best_size_reg <= '0;
            best_brow_reg <= '0;
            best_bcol_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (!stall)
            begin
                s1_valid_reg <= accept;
            end
            if (advance)
            begin
                if (s1_ctl_reg.last)
                begin
                    left_reg      <= '0;
                    diag_reg      <= '0;
                    best_size_reg <= '0;
                    best_brow_reg <= '0;
                    best_bcol_reg <= '0;
                end
                else
                begin
                    left_reg      <= left_next;
                    diag_reg      <= diag_next;
                    best_size_reg <= best_size_next;
                    best_brow_reg <= best_brow_next;
                    best_bcol_reg <= best_bcol_next;
                end
            end
            if (advance && s1_ctl_reg.last)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_ctl_reg <= ctl_in;
            s1_col_reg <= col_in;
            s1_row_reg <= row_in;
        end
        if (advance && s1_ctl_reg.last)
        begin
            out_row_reg  <= POS_OUT_W'(top_row);
            out_col_reg  <= POS_OUT_W'(top_col);
            out_side_reg <= SIDE_OUT_W'(best_size_next);
        end
    end

    assign m_tvalid  = out_valid_reg;
    assign best_row  = out_row_reg;
    assign best_col  = out_col_reg;
    assign best_side = out_side_reg;

`ifndef SYNTHESIS
    a_best_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        advance && !s1_ctl_reg.last |=> best_size_reg >= $past(best_size_reg))
        else $error("best side shrank within a map");

    a_side_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> ({1'b0, wr_data} <= ({1'b0, SIDE_W'(s1_col_reg)} + 1'b1)))
        else $error("square side exceeds column position");

    a_stall_holds_end: assert property (@(posedge clk) disable iff (!rst_n)
        stall |=> s1_valid_reg && s1_ctl_reg.last)
        else $error("end beat lost while result register busy");
`endif

endmodule

/* hdl/largest_empty_square_finder_top.sv */
// Top level of the largest empty square finder.
//
// Input stream: one map byte per beat on s_tdata, s_tlast marks the last
// byte of a map. '.' is a free cell, newline ends a row, any other byte
// is an obstacle. Output stream: one beat per map on m_tdata with the
// top-left row, column and side of the largest all-free square (side 0
// and position 0 when no cell is free). Ties keep the earliest corner.
//
// Throughput: one byte per cycle while s_tready is high. Each byte is read
// from the line store at the accept edge; its new side is written back as
// it leaves the update stage, which also loads the result on the end beat.
// A same-column access only recurs after a newline, so no forwarding.
//
// Reset clears all counters and flags at once; no clearing pass over
// the line store, since a fill mark masks entries never written.
// When the receiver stalls the result register holds; further bytes are
// still taken until the next end beat reaches the update stage, which
// then waits and drops s_tready until the result is taken.
module largest_empty_square_finder_top #(
    parameter int MAX_COLS = 1024,
    parameter int MAX_ROWS = 1024
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [lesf_pkg::CELL_W-1:0]      s_tdata,   // [7:0] cell_byte
    input  logic                             s_tlast,   // map_end
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [9:0] best_row, [19:10] best_col, [30:20] best_side, [31] zero
    output logic [lesf_pkg::M_TDATA_W-1:0]   m_tdata
);
    import lesf_pkg::*;

    localparam int COL_W   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int ROW_W   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int MIN_DIM = (MAX_COLS < MAX_ROWS) ? MAX_COLS : MAX_ROWS;
    localparam int SIDE_W  = $clog2(MIN_DIM + 1);

    logic              accept;
    logic              stall;
    ctl_t              scan_ctl;
    logic [COL_W-1:0]  scan_col;
    logic [ROW_W-1:0]  scan_row;
    logic [SIDE_W-1:0] rd_data;
    logic              wr_en;
    logic [COL_W-1:0]  wr_addr;
    logic [SIDE_W-1:0] wr_data;
    logic [POS_OUT_W-1:0]  best_row;
    logic [POS_OUT_W-1:0]  best_col;
    logic [SIDE_OUT_W-1:0] best_side;

    assign s_tready = !stall;
    assign accept   = s_tvalid && s_tready;

    // position tracking; read address is the current column
    lesf_scan #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .cell_byte (s_tdata),
        .map_end   (s_tlast),
        .ctl       (scan_ctl),
        .col       (scan_col),
        .row       (scan_row)
    );

    // previous row's sides
    lesf_line_store #(
        .DEPTH  (MAX_COLS),
        .ADDR_W (COL_W),
        .DATA_W (SIDE_W)
    ) u_line_store (
        .clk     (clk),
        .rd_en   (accept),
        .rd_addr (scan_col),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    // min-of-three update, best tracking, result register
    lesf_update #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_update (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .ctl_in    (scan_ctl),
        .col_in    (scan_col),
        .row_in    (scan_row),
        .rd_data   (rd_data),
        .stall     (stall),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .best_row  (best_row),
        .best_col  (best_col),
        .best_side (best_side)
    );

    assign m_tdata = {1'b0, best_side, best_col, best_row};

`ifndef SYNTHESIS
    // only reads whose data is used matter; first-row reads are masked
    a_no_same_entry: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en && accept && (scan_ctl.op == OP_CELL) && scan_ctl.above_valid
        |-> wr_addr != scan_col)
        else $error("line store read and write hit the same entry");
`endif

endmodule

/* sim/largest_empty_square_finder_top_tb.sv */
// Self-checking stream testbench for the largest empty square finder.
module largest_empty_square_finder_top_tb;
    import lesf_pkg::*;

    // Geometry of the block as instantiated (default parameters)
    localparam int MAX_COLS = 1024;
    localparam int MAX_ROWS = 1024;

    // Obstacle byte used where a plain obstacle is wanted
    localparam logic [CELL_W-1:0] OBSTACLE_CHAR = 8'h78;   // 'x'

    // Random phase sizing
    localparam int RANDOM_BEATS = 700;
    localparam int RANDOM_MAPS  = 20;

    // Cycles with no beat on either side before the run is declared hung.
    // Worst legal quiet spell is a sender gap plus a receiver stall plus
    // the result path through the update stage, far below this.
    localparam int QUIET_LIMIT = 2000;

    // Drain time after the last expected result
    localparam int TAIL_CYCLES = 10;

    logic                 clk      = 1'b0;
    logic                 rst_n    = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [CELL_W-1:0]    s_tdata  = '0;
    logic                 s_tlast  = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    // One result beat: top-left corner and side of the largest square
    typedef struct packed {
        logic [POS_OUT_W-1:0]  row;
        logic [POS_OUT_W-1:0]  col;
        logic [SIDE_OUT_W-1:0] side;
    } square_t;

    square_t expected_squares[$];

    // Predictor state: one row of square sides plus the running scan
    logic [SIDE_OUT_W-1:0] line_sides [0:MAX_COLS-1];
    logic [SIDE_OUT_W-1:0] left_side;
    logic [SIDE_OUT_W-1:0] diag_side;
    logic [SIDE_OUT_W-1:0] best_side;
    logic [POS_OUT_W-1:0]  cur_row;
    logic [POS_OUT_W-1:0]  cur_col;
    logic [POS_OUT_W-1:0]  best_brow;
    logic [POS_OUT_W-1:0]  best_bcol;
    logic                  rows_full;
    logic                  cols_full;

    int beats_sent    = 0;
    int maps_sent     = 0;
    int mismatch_cnt  = 0;
    int quiet_cycles  = 0;

    // Remaining beats of a no-idle stretch, per side
    int send_run = 0;
    int recv_run = 0;

    largest_empty_square_finder_top u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Hang detection: any accepted beat on either side restarts the count
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("timeout: no beat for %0d cycles", QUIET_LIMIT);
            $display("largest_empty_square_finder_top_tb: errors");
            $finish;
        end
    end

    // Per-beat wait drawn at random, with occasional stretches of no idling
    function automatic int draw_wait(inout int run_left);
        if (run_left > 0)
        begin
            run_left--;
            return 0;
        end
        if ($urandom_range(0, 19) == 0)
        begin
            run_left = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 6);
    endfunction

    // Clear everything but the line store: done at reset and after map end
    function automatic void start_new_map();
        left_side = '0;
        diag_side = '0;
        best_side = '0;
        cur_row   = '0;
        cur_col   = '0;
        best_brow = '0;
        best_bcol = '0;
        rows_full = 1'b0;
        cols_full = 1'b0;
    endfunction

    // Scan one accepted byte; on the map end beat queue the expected square
    function automatic void predict_byte(input logic [CELL_W-1:0] b, input logic last);
        logic [SIDE_OUT_W-1:0] up;
        logic [SIDE_OUT_W-1:0] low3;
        logic [SIDE_OUT_W-1:0] side;
        logic [SIDE_OUT_W-1:0] corner;
        square_t               sq;
        if (!rows_full)
        begin
            if (b == ROW_END_CHAR)
            begin
                left_side = '0;
                diag_side = '0;
                cur_col   = '0;
                cols_full = 1'b0;
                if (cur_row == MAX_ROWS - 1)
                    rows_full = 1'b1;
                else
                    cur_row = cur_row + 1'b1;
            end
            else if (!cols_full)
            begin
                // nothing above the first row
                up   = (cur_row == 0) ? '0 : line_sides[cur_col];
                low3 = (up < left_side) ? up : left_side;
                if (diag_side < low3)
                    low3 = diag_side;
                side = (b == FREE_CHAR) ? low3 + 1'b1 : '0;
                diag_side = up;
                left_side = side;
                line_sides[cur_col] = side;
                // strictly larger only: first corner in scan order wins ties
                if (side > best_side)
                begin
                    best_side = side;
                    best_brow = cur_row;
                    best_bcol = cur_col;
                end
                if (cur_col == MAX_COLS - 1)
                    cols_full = 1'b1;
                else
                    cur_col = cur_col + 1'b1;
            end
        end
        if (last)
        begin
            sq = '0;
            if (best_side != 0)
            begin
                corner = {1'b0, best_brow} + 1'b1 - best_side;
                sq.row = corner[POS_OUT_W-1:0];
                corner = {1'b0, best_bcol} + 1'b1 - best_side;
                sq.col = corner[POS_OUT_W-1:0];
                sq.side = best_side;
            end
            expected_squares.push_back(sq);
            start_new_map();
        end
    endfunction

    // Send one map byte; prediction runs at the accepting edge
    task automatic send_byte(input logic [CELL_W-1:0] b, input logic last);
        int gap;
        gap = draw_wait(send_run);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tdata  <= b;
        s_tlast  <= last;
        s_tvalid <= 1'b1;
        do @(posedge clk); while (!s_tready);
        predict_byte(b, last);
        beats_sent++;
        if (last)
            maps_sent++;
    endtask

    // Text map; the final character carries the map end flag
    task automatic send_text(input string txt);
        for (int i = 0; i < txt.len(); i++)
            send_byte(txt[i], i == txt.len() - 1);
    endtask

    // Hold the sender until every outstanding result has come back
    task automatic wait_results_drained();
        s_tvalid <= 1'b0;
        while (expected_squares.size() != 0)
            @(posedge clk);
    endtask

    // Free cell with the given odds, otherwise any obstacle byte
    function automatic logic [CELL_W-1:0] rand_cell(input int free_pct);
        logic [CELL_W-1:0] b;
        if ($urandom_range(1, 100) <= free_pct)
            return FREE_CHAR;
        b = 8'($urandom_range(0, 255));
        if (b == FREE_CHAR || b == ROW_END_CHAR)
            b = OBSTACLE_CHAR;
        return b;
    endfunction

    // Short hand-built maps: empty, single cell, ties, ragged rows, odd bytes
    task automatic test_small_maps();
        send_text("\n");                 // no cell at all
        send_text(".");                  // one free cell, end on a cell
        send_text("..x..\n..x..\n");     // two equal squares, left one wins
        send_text(".x.\nx..\n");         // side 1 tie, earliest corner
        send_text("....\n.\n....");      // short middle row leaves stale entries
        // obstacles only, byte extremes among them
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(OBSTACLE_CHAR, 1'b0);
        send_byte(8'h2F, 1'b0);
        send_byte(8'h0B, 1'b1);
        wait_results_drained();
    endtask

    // Random maps, mostly well-formed with random content, some noise
    task automatic test_random_maps();
        int first_beat;
        int first_map;
        int kind;
        int width;
        int height;
        int free_pct;
        int trail;
        int len;
        int pick;
        first_beat = beats_sent;
        first_map  = maps_sent;
        while (beats_sent - first_beat < RANDOM_BEATS || maps_sent - first_map < RANDOM_MAPS)
        begin
            kind = $urandom_range(0, 9);
            if (kind <= 6)
            begin
                // rectangular map, optional trailing newline on the last row
                width    = $urandom_range(1, 10);
                height   = $urandom_range(1, 10);
                free_pct = $urandom_range(60, 100);
                trail    = $urandom_range(0, 1);
                for (int r = 0; r < height; r++)
                begin
                    for (int c = 0; c < width; c++)
                        send_byte(rand_cell(free_pct),
                                  r == height - 1 && c == width - 1 && trail == 0);
                    if (r < height - 1 || trail != 0)
                        send_byte(ROW_END_CHAR, r == height - 1);
                end
            end
            else if (kind == 7)
            begin
                // ragged rows, empty ones allowed
                height   = $urandom_range(2, 8);
                free_pct = $urandom_range(70, 100);
                for (int r = 0; r < height; r++)
                begin
                    len = $urandom_range(0, 12);
                    for (int c = 0; c < len; c++)
                        send_byte(rand_cell(free_pct), 1'b0);
                    send_byte(ROW_END_CHAR, r == height - 1);
                end
            end
            else if (kind == 8)
            begin
                // byte noise
                len = $urandom_range(1, 30);
                for (int i = 0; i < len; i++)
                begin
                    pick = $urandom_range(0, 2);
                    send_byte(pick == 0 ? FREE_CHAR :
                              pick == 1 ? ROW_END_CHAR : 8'($urandom_range(0, 255)),
                              i == len - 1);
                end
            end
            else
                send_byte(8'($urandom_range(0, 255)), 1'b1);
            if ($urandom_range(0, 7) == 0)
                wait_results_drained();
        end
    endtask

    // Result side: random stalls, every beat checked against the queue head
    initial
    begin : result_check
        int               stall;
        square_t          want;
        logic [POS_OUT_W-1:0]  got_row;
        logic [POS_OUT_W-1:0]  got_col;
        logic [SIDE_OUT_W-1:0] got_side;
        forever
        begin
            stall = draw_wait(recv_run);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
            got_row  = m_tdata[9:0];
            got_col  = m_tdata[19:10];
            got_side = m_tdata[30:20];
            if (expected_squares.size() == 0)
            begin
                if (mismatch_cnt < 10)
                    $display("unexpected result: row %0d col %0d side %0d",
                             got_row, got_col, got_side);
                mismatch_cnt++;
            end
            else
            begin
                want = expected_squares.pop_front();
                if (got_row != want.row || got_col != want.col || got_side != want.side)
                begin
                    if (mismatch_cnt < 10)
                        $display("mismatch: expected row %0d col %0d side %0d, got %0d %0d %0d",
                                 want.row, want.col, want.side, got_row, got_col, got_side);
                    mismatch_cnt++;
                end
            end
        end
    end

    initial
    begin
        for (int i = 0; i < MAX_COLS; i++)
            line_sides[i] = '0;
        start_new_map();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_small_maps();
        test_random_maps();

        s_tvalid <= 1'b0;
        while (expected_squares.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatch_cnt == 0)
            $display("largest_empty_square_finder_top_tb: clean");
        else
            $display("largest_empty_square_finder_top_tb: errors");
        $finish;
    end

endmodule

/* largest_empty_square_finder_top.f */
hdl/lesf_pkg.sv
hdl/lesf_line_store.sv
hdl/lesf_scan.sv
hdl/lesf_update.sv
hdl/largest_empty_square_finder_top.sv
sim/largest_empty_square_finder_top_tb.sv
